// File: sv/cerv_pkg.sv
// Package: shared constants, types and the raised-cosine weight table.
`timescale 1ns / 1ps
`default_nettype none
package cerv_pkg;

  localparam int COS_TABLE_DEPTH = 256;
  localparam int HALF_TURN_DEG   = 180;
  // pi in Q30, the angle of a half turn of HALF_TURN_DEG degrees
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q30 = 64'd1073741824;

  localparam int IDX_W   = $clog2(COS_TABLE_DEPTH + 1);
  localparam int DVD_W   = 32 + $clog2(COS_TABLE_DEPTH);
  localparam int VAL_W   = 16;
  localparam int STEP_W  = 20;
  localparam int DUR_W   = 32;
  localparam int SEL_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RAMP = 2'd1,
    ST_DONE = 2'd2
  } ramp_stage_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CMP,
    S_DIV,
    S_LOOK,
    S_MIX,
    S_EMIT
  } seq_state_t;

  typedef logic [VAL_W-1:0] weight_tab_t [0:COS_TABLE_DEPTH];

  // floor(num / den) by shift and subtract
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // weight = (1 - cos(pi*i/depth)) / 2 in Q15, cosine by 8-term Taylor series in Q30
  function automatic weight_tab_t build_weights();
    weight_tab_t tab;
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint c;
    int unsigned j;
    int unsigned mirror;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      mirror = COS_TABLE_DEPTH - i;
      j = (i <= mirror) ? i : mirror;
      x = (PI_Q30 * j) / COS_TABLE_DEPTH;
      term = ONE_Q30;
      sum = ONE_Q30;
      for (int k = 1; k <= 8; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = udiv64(term, 64'((2 * k - 1) * (2 * k)));
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      c = (sum + 16384) >>> 15;
      if (i <= mirror) tab[i] = VAL_W'((32768 - c) >>> 1);
      else tab[i] = VAL_W'((32768 + c) >>> 1);
    end
    return tab;
  endfunction

  localparam weight_tab_t WEIGHT_TABLE = build_weights();

endpackage
`default_nettype wire

// File: sv/cerv_ifs.sv
// Interfaces: tick input, result output and register write channels.
`timescale 1ns / 1ps
`default_nettype none
interface cerv_sample_if import cerv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] time_step;
  logic [VAL_W-1:0]  present_value;
  modport source (output valid, time_step, present_value, input ready);
  modport sink (input valid, time_step, present_value, output ready);
endinterface

interface cerv_result_if import cerv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] eased_value;
  logic             ongoing;
  logic [SEL_W-1:0] sample_index;
  modport source (output valid, eased_value, ongoing, sample_index, input ready);
  modport sink (input valid, eased_value, ongoing, sample_index, output ready);
endinterface

interface cerv_cfg_if import cerv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/cerv_div.sv
// Serial restoring divider: one quotient bit per cycle, table index from elapsed/duration.
`timescale 1ns / 1ps
`default_nettype none
module cerv_div import cerv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DUR_W-1:0] divisor,
  output logic                  done,
  output logic [IDX_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DUR_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DUR_W:0]   trial;
  logic             ge;

  assign trial = {rem, dvd[DVD_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DVD_W-2:0], 1'b0};
      rem      <= ge ? DUR_W'(trial - {1'b0, divisor}) : trial[DUR_W-1:0];
      quotient <= {quotient[IDX_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: sv/cerv_mix.sv
// Serial blend: start*(1-w) + target*w, one weight bit per cycle, rounded to Q15.
`timescale 1ns / 1ps
`default_nettype none
module cerv_mix import cerv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] start_val,
  input  wire logic [VAL_W-1:0] target_val,
  input  wire logic [VAL_W-1:0] weight,
  output logic                  done,
  output logic [VAL_W-1:0]      value
);

  localparam int ACC_W = 2 * VAL_W + 1;
  localparam int CNT_W = $clog2(VAL_W + 1);
  localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (VAL_W - 2);

  logic [VAL_W-1:0] wsh;
  logic [VAL_W-1:0] ush;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] rnd;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign rnd   = acc + ROUND;
  assign value = rnd[2*VAL_W-2:VAL_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VAL_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      wsh <= weight;
      ush <= VAL_W'(17'd32768 - {1'b0, weight});
      acc <= '0;
    end else if (busy) begin
      wsh <= {wsh[VAL_W-2:0], 1'b0};
      ush <= {ush[VAL_W-2:0], 1'b0};
      acc <= {acc[ACC_W-2:0], 1'b0}
           + (wsh[VAL_W-1] ? ACC_W'(target_val) : '0)
           + (ush[VAL_W-1] ? ACC_W'(start_val) : '0);
    end
  end

endmodule
`default_nettype wire

// File: sv/cosine_eased_value_ramp_top.sv
// Top level: raised-cosine value ramp with serial divider and serial blender.
//
//   channel   dir   handshake        payload
//   samples   in    valid/ready      time_step, present_value
//   results   out   valid/ready      eased_value, ongoing, sample_index
//   cfg       in    valid/ready      index, data (ready always high)
//
// Start and after-done requests go from idle straight to emit, which registers the result
// once the output is free. Ramp requests pass add, compare, the bit-serial divider, lookup,
// the serial blender and emit; a zero elapsed skips the divider, the final tick goes from
// compare to emit. One request in flight; the next is taken while a finished result waits.
// Synchronous reset restores the configuration registers and returns the ramp to idle.
`timescale 1ns / 1ps
`default_nettype none
module cosine_eased_value_ramp_top import cerv_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  cerv_sample_if.sink   samples,
  cerv_result_if.source results,
  cerv_cfg_if.sink      cfg
);

  logic [VAL_W-1:0]  target_value;
  logic [DUR_W-1:0]  ramp_duration;
  logic [SEL_W-1:0]  sample_after;

  ramp_stage_t       stage;
  logic [DUR_W-1:0]  elapsed;
  logic [VAL_W-1:0]  start_value;
  logic [STEP_W-1:0] step;
  logic [IDX_W-1:0]  idx;
  logic [VAL_W-1:0]  res_value;
  logic              res_ongoing;

  seq_state_t        state, state_next;
  logic              div_start, mix_start, emit;
  logic              div_done, mix_done;
  logic [IDX_W-1:0]  div_q;
  logic [VAL_W-1:0]  mix_value;
  logic [DUR_W:0]    sum;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == S_IDLE);
  assign sum           = {1'b0, elapsed} + (DUR_W+1)'(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_value  <= 16'd32768;
      ramp_duration <= 32'd1000000;
      sample_after  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TARGET:   target_value  <= cfg.data[VAL_W-1:0];
        REG_DURATION: ramp_duration <= cfg.data[DUR_W-1:0];
        REG_SAMPLE:   sample_after  <= cfg.data[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    mix_start  = 1'b0;
    emit       = 1'b0;
    case (state)
      S_IDLE: begin
        if (samples.valid) begin
          state_next = (stage == ST_RAMP) ? S_ADD : S_EMIT;
        end
      end
      S_ADD: state_next = S_CMP;
      S_CMP: begin
        if (elapsed > ramp_duration) begin
          state_next = S_EMIT;
        end else if (elapsed == '0) begin
          state_next = S_LOOK;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: if (div_done) state_next = S_LOOK;
      S_LOOK: begin
        mix_start  = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: if (mix_done) state_next = S_EMIT;
      S_EMIT: begin
        if (!results.valid || results.ready) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= ST_IDLE;
      elapsed     <= '0;
      start_value <= '0;
    end else begin
      if (state == S_IDLE && samples.valid && stage == ST_IDLE) begin
        stage       <= ST_RAMP;
        elapsed     <= '0;
        start_value <= samples.present_value;
      end
      if (state == S_ADD) elapsed <= sum[DUR_W] ? '1 : sum[DUR_W-1:0];
      if (state == S_CMP && elapsed > ramp_duration) stage <= ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (samples.valid) begin
          step        <= samples.time_step;
          res_value   <= samples.present_value;
          res_ongoing <= (stage == ST_IDLE);
        end
      end
      S_CMP: begin
        idx         <= '0;
        res_value   <= target_value;
        res_ongoing <= 1'b0;
      end
      S_DIV: if (div_done) idx <= div_q;
      S_MIX: begin
        if (mix_done) begin
          res_value   <= mix_value;
          res_ongoing <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) results.valid <= 1'b0;
    else if (emit) results.valid <= 1'b1;
    else if (results.ready) results.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.eased_value  <= res_value;
      results.ongoing      <= res_ongoing;
      results.sample_index <= sample_after;
    end
  end

  cerv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DVD_W'(elapsed) << $clog2(COS_TABLE_DEPTH)),
    .divisor  (ramp_duration),
    .done     (div_done),
    .quotient (div_q)
  );

  cerv_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .start      (mix_start),
    .start_val  (start_value),
    .target_val (target_value),
    .weight     (WEIGHT_TABLE[idx]),
    .done       (mix_done),
    .value      (mix_value)
  );

endmodule
`default_nettype wire

// File: verif/cosine_eased_value_ramp_top_tb.sv
// Self-checking testbench for the cosine eased value ramp, with random handshake stalls.
`timescale 1ns / 1ps
module cosine_eased_value_ramp_top_tb;
  import cerv_pkg::*;

  localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [DUR_W-1:0] DUR_MAX = 32'hFFFF_FFFF;
  localparam int STALL_PCT = 11;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [VAL_W-1:0] eased;
    logic             ongoing;
    logic [SEL_W-1:0] sel;
  } ramp_result_t;

  class ramp_scoreboard;
    int               cos_q15 [COS_TABLE_DEPTH+1];
    logic [VAL_W-1:0] target;
    logic [DUR_W-1:0] duration;
    logic [SEL_W-1:0] sample_sel;
    ramp_stage_t      stage;
    logic [DUR_W-1:0] elapsed;
    logic [VAL_W-1:0] start_val;
    ramp_result_t     pending[$];
    int unsigned      errors;
    int unsigned      checked;

    function new();
      longint unsigned angle;
      longint unsigned term;
      longint          acc;
      int unsigned     fold;
      int              mag;
      for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
        fold = (i <= COS_TABLE_DEPTH - i) ? i : COS_TABLE_DEPTH - i;
        angle = (HALF_TURN_Q30 * fold) / COS_TABLE_DEPTH;
        term = 64'd1 << 30;
        acc = 64'sd1 << 30;
        for (int k = 1; k <= 8; k++) begin
          term = (term * angle) >> 30;
          term = (term * angle) >> 30;
          term = term / 64'((2 * k - 1) * (2 * k));
          if (k % 2 == 1) acc -= longint'(term);
          else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
        mag = int'((acc + 16384) >>> 15);
        cos_q15[i] = (i <= COS_TABLE_DEPTH - i) ? mag : -mag;
      end
      target = 16'd32768;
      duration = 32'd1000000;
      sample_sel = '0;
      stage = ST_IDLE;
      elapsed = '0;
      start_val = '0;
      errors = 0;
      checked = 0;
    endfunction

    task report_mismatch(string what);
      if (errors < REPORT_CAP) $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_TARGET:   target = data[VAL_W-1:0];
        REG_DURATION: duration = data[DUR_W-1:0];
        REG_SAMPLE:   sample_sel = data[SEL_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic [STEP_W-1:0] step, logic [VAL_W-1:0] present);
      ramp_result_t    got;
      longint unsigned total;
      longint unsigned wgt;
      longint unsigned mix;
      int              idx;
      got.eased = present;
      case (stage)
        ST_IDLE: begin
          stage = ST_RAMP;
          elapsed = '0;
          start_val = present;
        end
        ST_RAMP: begin
          total = 64'(elapsed) + 64'(step);
          elapsed = (total > 64'(DUR_MAX)) ? DUR_MAX : total[DUR_W-1:0];
          idx = 0;
          if (duration != 0 && elapsed <= duration)
            idx = int'((64'(elapsed) * 64'(COS_TABLE_DEPTH)) / 64'(duration));
          wgt = 64'((32768 - cos_q15[idx]) >> 1);
          mix = (64'(start_val) * (64'd32768 - wgt) + 64'(target) * wgt + 64'd16384) >> 15;
          got.eased = mix[VAL_W-1:0];
          if (elapsed > duration) begin
            stage = ST_DONE;
            got.eased = target;
          end
        end
        default: ;
      endcase
      got.ongoing = (stage == ST_RAMP);
      got.sel = sample_sel;
      pending.push_back(got);
    endfunction

    task check_result(logic [VAL_W-1:0] eased, logic ongoing, logic [SEL_W-1:0] sel);
      ramp_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, eased_value %h", eased));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (eased !== want.eased)
        report_mismatch($sformatf("result %0d eased_value %h, want %h", checked, eased,
                                  want.eased));
      if (ongoing !== want.ongoing)
        report_mismatch($sformatf("result %0d ongoing %b, want %b", checked, ongoing,
                                  want.ongoing));
      if (sel !== want.sel)
        report_mismatch($sformatf("result %0d sample_index %h, want %h", checked, sel,
                                  want.sel));
    endtask
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  bit             calm = 1'b0;
  int unsigned    ticks_sent = 0;
  int unsigned    cfg_writes = 0;
  int unsigned    idle_cycles = 0;
  ramp_scoreboard sb;

  cerv_sample_if samples_if ();
  cerv_result_if results_if ();
  cerv_cfg_if    cfg_if ();

  cosine_eased_value_ramp_top u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [VAL_W-1:0] pick_level();
    case ($urandom_range(5, 0))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3, 4: return VAL_W'($urandom_range(32768, 0));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic send_tick(input logic [STEP_W-1:0] step, input logic [VAL_W-1:0] present);
    @(negedge clk);
    while (!calm && $urandom_range(99, 0) < STALL_PCT) begin
      samples_if.valid <= 1'b0;
      @(negedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.time_step <= step;
    samples_if.present_value <= present;
    do @(posedge clk); while (!samples_if.ready);
    sb.note_tick(step, present);
    ticks_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_register(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    samples_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      results_if.ready <= calm || ($urandom_range(99, 0) >= STALL_PCT);
    end
  end

  always @(posedge clk)
    if (!rst && results_if.valid && results_if.ready)
      sb.check_result(results_if.eased_value, results_if.ongoing, results_if.sample_index);

  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) ||
        (results_if.valid && results_if.ready) || (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int              n;
    int unsigned     max_step;
    longint unsigned margin;
    longint unsigned span;
    sb = new();
    samples_if.valid = 1'b0;
    samples_if.time_step = '0;
    samples_if.present_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_TARGET;
    cfg_if.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // start request captures the value; step is ignored
    send_tick(20'hFFFFF, 16'hFFFF);
    send_tick(20'h00000, 16'h0000);
    settle();
    write_reg(REG_DURATION, 32'd0);
    send_tick(20'h00000, 16'h5555);
    send_tick(20'h00000, 16'hAAAA);
    settle();
    write_reg(REG_DURATION, 32'd1000);
    send_tick(20'd1000, 16'h1234);
    send_tick(20'd0, 16'h0001);
    settle();
    write_reg(REG_TARGET, 32'hFFFF_0000);
    write_reg(REG_SAMPLE, 32'hFFFF_FFFF);
    write_reg(REG_DURATION, DUR_MAX);
    send_tick(20'hFFFFF, 16'h0000);
    send_tick(20'h55555, 16'hFFFF);
    send_tick(20'hAAAAA, 16'h8000);
    settle();
    write_reg(REG_TARGET, 32'h0000_FFFF);
    write_reg(REG_SAMPLE, 32'h0000_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_tick(20'd1, 16'h7FFF);
    send_tick(20'd1000000, 16'h8001);
    settle();
    write_reg(REG_TARGET, 32'h0000_8000);
    write_reg(REG_DURATION, sb.elapsed + 32'd500);
    send_tick(20'd499, 16'h00FF);
    send_tick(20'd1, 16'hFF00);
    settle();

    // ramp phases: duration always kept ahead of the elapsed time
    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph == 3);
      n = $urandom_range(110, 50);
      case ($urandom_range(3, 0))
        0: max_step = 20'hFFFFF;
        1: max_step = 65535;
        2: max_step = $urandom_range(1023, 0);
        default: max_step = $urandom_range(20'hFFFFF, 0);
      endcase
      margin = longint'(n) * max_step;
      span = 64'(sb.elapsed) + margin * $urandom_range(4, 1) + $urandom_range(255, 0);
      if ($urandom_range(7, 0) == 0 || span > 64'(DUR_MAX)) span = 64'(DUR_MAX);
      if ($urandom_range(2, 0) != 0) write_reg(REG_TARGET, {16'($urandom), pick_level()});
      write_reg(REG_DURATION, span[DUR_W-1:0]);
      if ($urandom_range(2, 0) != 0) write_reg(REG_SAMPLE, $urandom);
      if ($urandom_range(5, 0) == 0) write_reg(REG_UNUSED, $urandom);
      repeat (n) send_tick(STEP_W'($urandom_range(max_step, 0)), VAL_W'($urandom));
      settle();
    end

    // long run of large steps under the longest duration, no idling
    write_reg(REG_DURATION, DUR_MAX);
    calm = 1'b1;
    write_reg(REG_TARGET, {16'($urandom), pick_level()});
    write_reg(REG_SAMPLE, $urandom);
    repeat (150)
      send_tick(STEP_W'($urandom_range(20'hFFFFF, 20'hC0000)), VAL_W'($urandom));
    settle();
    calm = 1'b0;
    send_tick(20'h00000, 16'hFFFF);
    send_tick(STEP_W'($urandom), 16'h0000);
    settle();

    // zero duration ends the ramp, then requests after done
    write_reg(REG_DURATION, 32'd0);
    send_tick(20'h00000, 16'h4000);
    settle();
    for (int grp = 0; grp < 5; grp++) begin
      write_reg(REG_TARGET, {16'($urandom), pick_level()});
      write_reg(REG_SAMPLE, $urandom);
      case ($urandom_range(2, 0))
        0: write_reg(REG_DURATION, 32'd0);
        1: write_reg(REG_DURATION, DUR_MAX);
        default: write_reg(REG_DURATION, $urandom);
      endcase
      repeat (50) send_tick(STEP_W'($urandom), VAL_W'($urandom));
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
    $display("ramp run: %0d requests, %0d results checked, %0d register writes",
             ticks_sent, sb.checked, cfg_writes);
    $display("elapsed time ended at %0d us in stage %s, %0d mismatches",
             sb.elapsed, sb.stage.name(), sb.errors);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
